/* hdl/scf_pkg.sv */
// Shared types, command codes, frame constants and frame encoding functions.
package scf_pkg;

    localparam int OP_W        = 3;
    localparam int IDX_W       = 4;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [OP_W-1:0] OP_ENABLE = 3'd0;
    localparam logic [OP_W-1:0] OP_SPEED  = 3'd1;
    localparam logic [OP_W-1:0] OP_REL    = 3'd2;
    localparam logic [OP_W-1:0] OP_ABS    = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CHECK_BYTE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_REV = 1'd1;

    localparam logic [7:0]  CHECK_BYTE_RST     = 8'h6B;
    localparam logic [15:0] PULSES_PER_REV_RST = 16'd3200;

    localparam logic [7:0] FC_ENABLE  = 8'hF3;
    localparam logic [7:0] ENABLE_KEY = 8'hAB;
    localparam logic [7:0] FC_SPEED   = 8'hF6;
    localparam logic [7:0] FC_MOVE    = 8'hFD;
    localparam logic [7:0] FC_STOP    = 8'hFE;
    localparam logic [7:0] STOP_KEY   = 8'h98;
    localparam logic [7:0] ABS_MARK   = 8'h01;

    // 92160 = 2^11 * 45: shift out the power of two, then divide by 45
    // through a reciprocal multiply with one correction step.
    localparam int              PROD_W      = 40;
    localparam int              PRE_SHIFT   = 11;
    localparam int              X_W         = PROD_W - PRE_SHIFT;
    localparam int              RECIP_W     = 30;
    localparam int              RECIP_SHIFT = 35;
    localparam int              XM_W        = X_W + RECIP_W;
    localparam int              Q_W         = XM_W - RECIP_SHIFT;
    localparam int              REM_W       = 30;
    localparam logic [RECIP_W-1:0] RECIP_M  = 30'd763549741;
    localparam logic [5:0]      DIV_ODD     = 6'd45;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [7:0]      addr;
        logic            en;
        logic [7:0]      dir;
        logic [15:0]     spd;
        logic [7:0]      acc;
        logic [31:0]     pulses;
    } cmd_t;

    typedef struct packed {
        logic              nonempty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    function automatic logic op_known(input logic [OP_W-1:0] op);
        logic known;
        begin
            unique case (op)
                OP_ENABLE, OP_SPEED, OP_REL, OP_ABS, OP_STOP: known = 1'b1;
                default: known = 1'b0;
            endcase
            return known;
        end
    endfunction

    function automatic logic [IDX_W-1:0] frame_len(input logic [OP_W-1:0] op);
        logic [IDX_W-1:0] len;
        begin
            unique case (op)
                OP_ENABLE:      len = 4'd6;
                OP_SPEED:       len = 4'd8;
                OP_REL, OP_ABS: len = 4'd13;
                OP_STOP:        len = 4'd5;
                default:        len = 4'd0;
            endcase
            return len;
        end
    endfunction

    function automatic logic [7:0] frame_byte(input cmd_t c, input logic [IDX_W-1:0] idx,
                                              input logic [7:0] chk);
        logic [7:0] b;
        begin
            b = 8'h00;
            unique case (c.op)
                OP_ENABLE:
                begin
                    unique case (idx)
                        4'd0:    b = c.addr;
                        4'd1:    b = FC_ENABLE;
                        4'd2:    b = ENABLE_KEY;
                        4'd3:    b = {7'd0, c.en};
                        4'd5:    b = chk;
                        default: b = 8'h00;
                    endcase
                end
                OP_SPEED:
                begin
                    unique case (idx)
                        4'd0:    b = c.addr;
                        4'd1:    b = FC_SPEED;
                        4'd2:    b = c.dir;
                        4'd3:    b = c.spd[15:8];
                        4'd4:    b = c.spd[7:0];
                        4'd5:    b = c.acc;
                        4'd7:    b = chk;
                        default: b = 8'h00;
                    endcase
                end
                OP_REL, OP_ABS:
                begin
                    unique case (idx)
                        4'd0:    b = c.addr;
                        4'd1:    b = FC_MOVE;
                        4'd2:    b = c.dir;
                        4'd3:    b = c.spd[15:8];
                        4'd4:    b = c.spd[7:0];
                        4'd5:    b = c.acc;
                        4'd6:    b = c.pulses[31:24];
                        4'd7:    b = c.pulses[23:16];
                        4'd8:    b = c.pulses[15:8];
                        4'd9:    b = c.pulses[7:0];
                        4'd10:   b = (c.op == OP_ABS) ? ABS_MARK : 8'h00;
                        4'd12:   b = chk;
                        default: b = 8'h00;
                    endcase
                end
                OP_STOP:
                begin
                    unique case (idx)
                        4'd0:    b = c.addr;
                        4'd1:    b = FC_STOP;
                        4'd2:    b = STOP_KEY;
                        4'd4:    b = chk;
                        default: b = 8'h00;
                    endcase
                end
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

/* hdl/stepper_command_framer.sv */
// Top level of the stepper command framer: configuration registers and the three stages.
// Each accepted command becomes one serial frame, sent one byte per beat on tx_byte with
// last_byte set on its final byte: 6 bytes for enable, 8 for speed mode, 13 for either
// move and 5 for stop; opcodes 5 to 7 are accepted and produce nothing. Commands can be
// pushed back to back until full rises. The output runs at one byte per cycle while it is
// popped every cycle, and frames then follow each other with no gap; the output serializer
// sets the sustained rate. On its way to the output a command passes the two-stage
// angle-to-pulse pipeline (a 24x16 multiply, then a reciprocal multiply by 1/45 with one
// correction), is written into the command queue, is loaded into the serializer, and its
// first byte is registered at the output. Full rises once four commands sit in the pipeline
// and the queue together; beyond those, one command can be in the serializer and the last
// byte of the one before it in the output register. The configuration port is always ready;
// writes belong to idle periods.
module stepper_command_framer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [scf_pkg::OP_W-1:0]      opcode,
    input  logic [7:0]                    motor_addr,
    input  logic                          enable_flag,
    input  logic [7:0]                    direction,
    input  logic [15:0]                   speed_value,
    input  logic [7:0]                    accel_level,
    input  logic [31:0]                   pulse_count,
    input  logic [23:0]                   angle_q8,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    tx_byte,
    output logic                          last_byte,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [scf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [scf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import scf_pkg::*;

    logic [7:0]  check_byte_reg;
    logic [15:0] pulses_per_rev_reg;
    logic        take;
    logic        enq_valid;
    cmd_t        enq_cmd;
    cmd_t        head;
    q_stat_t     q_stat;
    logic        q_pop;

    assign cfg_ready = 1'b1;
    assign take      = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_byte_reg     <= CHECK_BYTE_RST;
            pulses_per_rev_reg <= PULSES_PER_REV_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CHECK_BYTE:     check_byte_reg     <= cfg_data[7:0];
                REG_PULSES_PER_REV: pulses_per_rev_reg <= cfg_data;
                default:            check_byte_reg     <= check_byte_reg;
            endcase
        end
    end

    scf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .opcode         (opcode),
        .motor_addr     (motor_addr),
        .enable_flag    (enable_flag),
        .direction      (direction),
        .speed_value    (speed_value),
        .accel_level    (accel_level),
        .pulse_count    (pulse_count),
        .angle_q8       (angle_q8),
        .pulses_per_rev (pulses_per_rev_reg),
        .q_stat         (q_stat),
        .full           (full),
        .enq_valid      (enq_valid),
        .enq_cmd        (enq_cmd)
    );

    scf_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (enq_valid),
        .wr_cmd (enq_cmd),
        .rd_en  (q_pop),
        .head   (head),
        .stat   (q_stat)
    );

    scf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_stat     (q_stat),
        .check_byte (check_byte_reg),
        .pop        (pop),
        .q_pop      (q_pop),
        .empty      (empty),
        .tx_byte    (tx_byte),
        .last_byte  (last_byte)
    );

endmodule

/* hdl/scf_front.sv */
// Front end: accepts commands, converts the angle to pulses and feeds the command queue.
module scf_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    take,
    input  logic [scf_pkg::OP_W-1:0] opcode,
    input  logic [7:0]              motor_addr,
    input  logic                    enable_flag,
    input  logic [7:0]              direction,
    input  logic [15:0]             speed_value,
    input  logic [7:0]              accel_level,
    input  logic [31:0]             pulse_count,
    input  logic [23:0]             angle_q8,
    input  logic [15:0]             pulses_per_rev,
    input  scf_pkg::q_stat_t        q_stat,
    output logic                    full,
    output logic                    enq_valid,
    output scf_pkg::cmd_t           enq_cmd
);
    import scf_pkg::*;

    logic              s1_valid_reg;
    cmd_t              s1_cmd_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic [PROD_W-1:0] s1_prod_next;
    logic              s2_valid_reg;
    cmd_t              s2_cmd_reg;
    logic [X_W-1:0]    s2_x_reg;
    logic [XM_W-1:0]   s2_xm_reg;
    logic [X_W-1:0]    s1_x;
    logic [XM_W-1:0]   s2_xm_next;
    logic [Q_W-1:0]    q_est;
    logic [REM_W-1:0]  q_times;
    logic [REM_W-1:0]  rem;
    logic [Q_W-1:0]    q_fix;
    logic [QCNT_W-1:0] occupancy;
    cmd_t              in_cmd;

    // Every command in the pipeline holds a reserved queue slot, so the pipeline never stalls.
    assign occupancy = q_stat.count + QCNT_W'(s1_valid_reg) + QCNT_W'(s2_valid_reg);
    assign full      = (occupancy >= QCNT_W'(QDEPTH));

    always_comb
    begin
        in_cmd.op     = opcode;
        in_cmd.addr   = motor_addr;
        in_cmd.en     = enable_flag;
        in_cmd.dir    = direction;
        in_cmd.spd    = speed_value;
        in_cmd.acc    = accel_level;
        in_cmd.pulses = pulse_count;
    end

    assign s1_prod_next = PROD_W'(angle_q8) * PROD_W'(pulses_per_rev);
    assign s1_x         = s1_prod_reg[PROD_W-1:PRE_SHIFT];
    assign s2_xm_next   = XM_W'(s1_x) * XM_W'(RECIP_M);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg  <= in_cmd;
        s1_prod_reg <= s1_prod_next;
        s2_cmd_reg  <= s1_cmd_reg;
        s2_x_reg    <= s1_x;
        s2_xm_reg   <= s2_xm_next;
    end

    // The reciprocal estimate is at most one below the true quotient.
    assign q_est   = s2_xm_reg[XM_W-1:RECIP_SHIFT];
    assign q_times = REM_W'(q_est) * REM_W'(DIV_ODD);
    assign rem     = REM_W'(s2_x_reg) - q_times;
    assign q_fix   = (rem >= REM_W'(DIV_ODD)) ? (q_est + Q_W'(1)) : q_est;

    always_comb
    begin
        enq_cmd = s2_cmd_reg;
        if (s2_cmd_reg.op == OP_ABS)
        begin
            enq_cmd.pulses = 32'(q_fix);
        end
    end

    // Unused opcodes are accepted and dropped here.
    assign enq_valid = s2_valid_reg && op_known(s2_cmd_reg.op);

endmodule

/* hdl/scf_queue.sv */
// Short command queue between the front end and the byte serializer.
module scf_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  scf_pkg::cmd_t    wr_cmd,
    input  logic             rd_en,
    output scf_pkg::cmd_t    head,
    output scf_pkg::q_stat_t stat
);
    import scf_pkg::*;

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    assign head          = mem[rd_ptr_reg];
    assign stat.nonempty = (count_reg != '0);
    assign stat.count    = count_reg;

endmodule

/* hdl/scf_back.sv */
// Back end: serializes queued commands into frame bytes through an output register.
module scf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  scf_pkg::cmd_t    head,
    input  scf_pkg::q_stat_t q_stat,
    input  logic [7:0]       check_byte,
    input  logic             pop,
    output logic             q_pop,
    output logic             empty,
    output logic [7:0]       tx_byte,
    output logic             last_byte
);
    import scf_pkg::*;

    logic              cur_valid_reg;
    cmd_t              cur_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              advance;
    logic              at_last;
    logic              load;

    assign advance = cur_valid_reg && (!out_valid_reg || pop);
    assign at_last = ((idx_reg + IDX_W'(1)) == frame_len(cur_reg.op));
    assign load    = q_stat.nonempty && (!cur_valid_reg || (advance && at_last));
    assign q_pop   = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (advance)
            begin
                if (at_last)
                begin
                    cur_valid_reg <= 1'b0;
                end
                idx_reg <= idx_reg + IDX_W'(1);
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= head;
        end
        if (advance)
        begin
            out_byte_reg <= frame_byte(cur_reg, idx_reg, check_byte);
            out_last_reg <= at_last;
        end
    end

    assign empty     = !out_valid_reg;
    assign tx_byte   = out_byte_reg;
    assign last_byte = out_last_reg;

endmodule
